>>> design/jack_normalization_probe_defines.svh
// assertion macros shared by the checker
`ifndef JACK_NORMALIZATION_PROBE_DEFINES_SVH
`define JACK_NORMALIZATION_PROBE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JNP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JNP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/jnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jnp_pkg;

    localparam int NUM_JACKS_DEF = 4;
    localparam int SENSE_W       = 4;
    localparam int MASK_W        = 4;
    localparam int PATTERN_W     = 32;
    localparam int THRESH_W      = 6;
    localparam int COUNT_W       = 6;
    localparam int POS_W         = 5;
    localparam int ADDR_W        = 2;

    localparam logic [POS_W-1:0]     WINDOW_LAST   = 5'd31;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 6'd63;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 32'hAAAA_AAAA;
    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 6'd3;

    localparam logic [ADDR_W-1:0] REG_PATTERN     = 2'd0;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CALIBRATING = 2'd2;

    typedef struct packed {
        logic                enable;
        logic                window_end;
        logic                driven_bit;
        logic [THRESH_W-1:0] threshold;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/jnp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module jnp_lane
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire jnp_pkg::lane_ctrl_t ctrl,
    input  wire                      sensed,
    output logic                     flag_next
);

    logic [jnp_pkg::COUNT_W-1:0] count_reg;
    logic [jnp_pkg::COUNT_W-1:0] count_next;
    logic [jnp_pkg::COUNT_W-1:0] count_sum;
    logic                        flag_reg;
    logic                        bump;

    always_comb
    begin
        bump       = ctrl.enable && (sensed != ctrl.driven_bit)
                     && (count_reg != jnp_pkg::COUNT_MAX);
        count_sum  = bump ? count_reg + jnp_pkg::COUNT_W'(1) : count_reg;
        count_next = count_sum;
        flag_next  = flag_reg;
        if (ctrl.enable && ctrl.window_end)
        begin
            flag_next  = count_sum > ctrl.threshold;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

`default_nettype wire

>>> design/jnp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module jnp_merge
#(
    parameter int NUM_JACKS = jnp_pkg::NUM_JACKS_DEF
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         load,
    input  wire  [NUM_JACKS-1:0]        flags,
    input  wire                         probe_in,
    input  wire                         out_stall,
    output logic                        in_stall,
    output logic                        out_valid,
    output logic                        probe_level,
    output logic [jnp_pkg::MASK_W-1:0]  plugged_mask
);

    logic [jnp_pkg::MASK_W-1:0] mask_new;
    logic                       out_valid_reg;
    logic                       probe_reg;
    logic [jnp_pkg::MASK_W-1:0] mask_reg;
    logic                       skid_valid_reg;
    logic                       skid_probe_reg;
    logic [jnp_pkg::MASK_W-1:0] skid_mask_reg;
    logic                       out_fire;
    logic                       out_free;

    genvar j;
    generate
        for (j = 0; j < jnp_pkg::MASK_W; j++)
        begin : g_mask
            if (j < NUM_JACKS)
            begin : g_on
                assign mask_new[j] = flags[j];
            end
            else
            begin : g_off
                assign mask_new[j] = 1'b0;
            end
        end
    endgenerate

    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (load)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                probe_reg <= skid_probe_reg;
                mask_reg  <= skid_mask_reg;
            end
        end
        else if (load)
        begin
            if (out_free)
            begin
                probe_reg <= probe_in;
                mask_reg  <= mask_new;
            end
            else
            begin
                skid_probe_reg <= probe_in;
                skid_mask_reg  <= mask_new;
            end
        end
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign probe_level  = probe_reg;
    assign plugged_mask = mask_reg;

endmodule

`default_nettype wire

>>> design/jack_normalization_probe.sv
`timescale 1ns / 1ps
`default_nettype none

// Jack detection by normalization probe. Each input transfer is one tick carrying the
// sensed level of every jack; it returns one result: the probe level to drive for the
// next tick and the current plugged-in mask. One tick is taken every clock cycle unless
// in_stall is high; its result is registered in the output register, or in the skid
// register while the output is stalled. Results come from per-jack mismatch counters,
// one lane per jack, and an output register with one skid stage. Configuration writes
// take effect on the next tick; calibration freezes the window and drives the probe low.
module jack_normalization_probe
#(
    parameter int NUM_JACKS = jnp_pkg::NUM_JACKS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [jnp_pkg::ADDR_W-1:0]       cfg_addr,
    input  wire  [jnp_pkg::PATTERN_W-1:0]    cfg_wdata,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [jnp_pkg::SENSE_W-1:0]      sensed_bits,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic                             probe_level,
    output logic [jnp_pkg::MASK_W-1:0]       plugged_mask
);

    logic [jnp_pkg::PATTERN_W-1:0] pattern_reg;
    logic [jnp_pkg::THRESH_W-1:0]  threshold_reg;
    logic                          calibrating_reg;
    logic [jnp_pkg::POS_W-1:0]     pos_reg;
    logic [jnp_pkg::POS_W-1:0]     pos_next;
    logic                          driven_reg;
    logic                          driven_next;
    logic                          in_fire;
    logic                          window_end;
    logic [NUM_JACKS-1:0]          flags_next;
    jnp_pkg::lane_ctrl_t           lane_ctrl;

    assign in_fire    = in_valid && !in_stall;
    assign window_end = pos_reg == jnp_pkg::WINDOW_LAST;

    always_comb
    begin
        pos_next    = pos_reg;
        driven_next = driven_reg;
        if (in_fire)
        begin
            if (calibrating_reg)
            begin
                driven_next = 1'b0;
            end
            else
            begin
                pos_next    = window_end ? '0 : pos_reg + jnp_pkg::POS_W'(1);
                driven_next = pattern_reg[pos_next];
            end
        end
    end

    assign lane_ctrl.enable     = in_fire && !calibrating_reg;
    assign lane_ctrl.window_end = window_end;
    assign lane_ctrl.driven_bit = driven_reg;
    assign lane_ctrl.threshold  = threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= jnp_pkg::PATTERN_RESET;
            threshold_reg   <= jnp_pkg::THRESH_RESET;
            calibrating_reg <= 1'b0;
            pos_reg         <= '0;
            driven_reg      <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            driven_reg <= driven_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    jnp_pkg::REG_PATTERN:
                    begin
                        pattern_reg <= cfg_wdata;
                    end
                    jnp_pkg::REG_THRESHOLD:
                    begin
                        threshold_reg <= cfg_wdata[jnp_pkg::THRESH_W-1:0];
                    end
                    jnp_pkg::REG_CALIBRATING:
                    begin
                        calibrating_reg <= cfg_wdata[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < NUM_JACKS; j++)
        begin : g_lane
            logic sensed;
            if (j < jnp_pkg::SENSE_W)
            begin : g_pin
                assign sensed = sensed_bits[j];
            end
            else
            begin : g_nopin
                assign sensed = 1'b0;
            end

            jnp_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (lane_ctrl),
                .sensed    (sensed),
                .flag_next (flags_next[j])
            );
        end
    endgenerate

    jnp_merge
    #(
        .NUM_JACKS (NUM_JACKS)
    )
    u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (in_fire),
        .flags        (flags_next),
        .probe_in     (driven_next),
        .out_stall    (out_stall),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .probe_level  (probe_level),
        .plugged_mask (plugged_mask)
    );

endmodule

`default_nettype wire

>>> design/jnp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "jack_normalization_probe_defines.svh"

module jnp_checker
(
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_stall,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire                         probe_level,
    input wire [jnp_pkg::MASK_W-1:0]   plugged_mask
);

    `JNP_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `JNP_CHECK_NEXT(a_out_stable, out_valid && out_stall, $stable(probe_level) && $stable(plugged_mask), "stalled result changed")
    `JNP_CHECK(a_stall_needs_result, in_stall, out_valid, "input stalled with no result pending")
    `JNP_CHECK_NEXT(a_transfer_gives_result, in_valid && !in_stall, out_valid, "no result after input transfer")

endmodule

bind jack_normalization_probe jnp_checker u_jnp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .probe_level  (probe_level),
    .plugged_mask (plugged_mask)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [jnp_pkg::ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_TICKS    = 1350;

    typedef struct packed {
        logic                       probe;
        logic [jnp_pkg::MASK_W-1:0] mask;
    } tick_result_t;

    // literal items carry the sensed bits as they are, the others carry a flip mask
    // against the probe level in force when the item goes out
    typedef struct packed {
        logic                        literal;
        logic [jnp_pkg::SENSE_W-1:0] bits;
    } tick_item_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_e;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [jnp_pkg::ADDR_W-1:0]    cfg_addr = '0;
    logic [jnp_pkg::PATTERN_W-1:0] cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [jnp_pkg::SENSE_W-1:0]   sensed_bits = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          probe_level;
    logic [jnp_pkg::MASK_W-1:0]    plugged_mask;

    jack_normalization_probe #(
        .NUM_JACKS (jnp_pkg::NUM_JACKS_DEF)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sensed_bits  (sensed_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .probe_level  (probe_level),
        .plugged_mask (plugged_mask)
    );

    always #5 clk = ~clk;

    // detector model state
    logic [jnp_pkg::PATTERN_W-1:0] det_pattern = jnp_pkg::PATTERN_RESET;
    logic [jnp_pkg::THRESH_W-1:0]  det_threshold = jnp_pkg::THRESH_RESET;
    logic                          det_calibrating = 1'b0;
    logic [jnp_pkg::POS_W-1:0]     det_position = '0;
    logic                          det_probe = 1'b0;
    logic [jnp_pkg::COUNT_W-1:0]   det_counts [jnp_pkg::MASK_W];
    logic [jnp_pkg::MASK_W-1:0]    det_plugged = '0;

    tick_item_t   pending_ticks [$];
    tick_result_t expected_results [$];
    int           errors = 0;
    int           ticks_queued = 0;
    int           results_seen = 0;

    initial begin
        for (int j = 0; j < jnp_pkg::MASK_W; j++)
        begin
            det_counts[j] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task predict_tick(input logic [jnp_pkg::SENSE_W-1:0] sensed);
        tick_result_t r;
        if (det_calibrating)
        begin
            det_probe = 1'b0;
        end
        else
        begin
            for (int j = 0; j < jnp_pkg::MASK_W; j++)
            begin
                if (sensed[j] != det_probe && det_counts[j] != jnp_pkg::COUNT_MAX)
                begin
                    det_counts[j] = det_counts[j] + 1'b1;
                end
            end
            if (det_position != jnp_pkg::WINDOW_LAST)
            begin
                det_position = det_position + 1'b1;
            end
            else
            begin
                for (int j = 0; j < jnp_pkg::MASK_W; j++)
                begin
                    det_plugged[j] = det_counts[j] > det_threshold;
                    det_counts[j]  = '0;
                end
                det_position = '0;
            end
            det_probe = det_pattern[det_position];
        end
        r.probe = det_probe;
        r.mask  = det_plugged;
        expected_results.push_back(r);
    endtask

    // driver: bursts of random length with random gaps
    int         burst_left;
    int         gap_left;
    tick_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sensed_bits <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_tick(sensed_bits);
            end
            if (!in_valid || !in_stall)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left != 0 && pending_ticks.size() != 0)
                begin
                    next_item = pending_ticks.pop_front();
                    in_valid    <= 1'b1;
                    sensed_bits <= next_item.literal
                                   ? next_item.bits
                                   : ({jnp_pkg::SENSE_W{det_probe}} ^ next_item.bits);
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (burst_left == 0 && gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    int          hold_requests = 0;
    int          holds_served;
    int          hold_left;
    int          mode_left;
    int          mode_cycle;
    stall_mode_e stall_mode;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            holds_served = 0;
            hold_left    = 0;
            mode_left    = 0;
            mode_cycle   = 0;
            stall_mode   = STALL_NONE;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 96);
                mode_cycle = 0;
            end
            mode_left--;
            mode_cycle++;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= (mode_cycle % 3 == 0);
                default:        out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // monitor
    tick_result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", 32'({probe_level, plugged_mask}), 0);
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (probe_level !== oldest.probe)
                begin
                    report_mismatch("probe_level", 32'(probe_level), 32'(oldest.probe));
                end
                if (plugged_mask !== oldest.mask)
                begin
                    report_mismatch("plugged_mask", 32'(plugged_mask), 32'(oldest.mask));
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL jack_normalization_probe");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [jnp_pkg::ADDR_W-1:0] addr,
                             input logic [jnp_pkg::PATTERN_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            jnp_pkg::REG_PATTERN:     det_pattern = value;
            jnp_pkg::REG_THRESHOLD:   det_threshold = value[jnp_pkg::THRESH_W-1:0];
            jnp_pkg::REG_CALIBRATING: det_calibrating = value[0];
            default:                  ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_literal(input logic [jnp_pkg::SENSE_W-1:0] bits);
        tick_item_t t;
        t.literal = 1'b1;
        t.bits    = bits;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // windows of ticks whose per-jack mismatch rate is 0, 32 or near the threshold
    task automatic queue_ticks(input int count);
        tick_item_t t;
        int         rate [jnp_pkg::MASK_W];
        int         lo;
        int         thr;
        thr = int'(det_threshold);
        for (int k = 0; k < count; k++)
        begin
            if (k % 32 == 0)
            begin
                for (int j = 0; j < jnp_pkg::MASK_W; j++)
                begin
                    lo = (thr > 2) ? thr - 2 : 0;
                    case ($urandom_range(0, 5))
                        0:       rate[j] = 0;
                        1:       rate[j] = 32;
                        default: rate[j] = $urandom_range(lo, thr + 3);
                    endcase
                    if (rate[j] > 32)
                    begin
                        rate[j] = 32;
                    end
                end
            end
            t.literal = ($urandom_range(0, 9) == 0);
            if (t.literal)
            begin
                t.bits = jnp_pkg::SENSE_W'($urandom_range(0, 15));
            end
            else
            begin
                for (int j = 0; j < jnp_pkg::SENSE_W; j++)
                begin
                    t.bits[j] = ($urandom_range(0, 31) < rate[j]);
                end
            end
            pending_ticks.push_back(t);
            ticks_queued++;
        end
    endtask

    task automatic wait_drained();
        while (results_seen < ticks_queued || pending_ticks.size() != 0 || in_valid
               || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every value of the sensed field under reset settings
        push_literal(4'h0);
        push_literal(4'hF);
        push_literal(4'h1);
        push_literal(4'h2);
        push_literal(4'h4);
        push_literal(4'h8);
        push_literal(4'hE);
        push_literal(4'hD);
        push_literal(4'hB);
        push_literal(4'h7);
        push_literal(4'h5);
        push_literal(4'hA);
        push_literal(4'h3);
        push_literal(4'hC);
        push_literal(4'h6);
        push_literal(4'h9);
        push_literal(4'hF);
        push_literal(4'h0);
        wait_drained();

        // index past the register list has no effect
        write_reg(REG_UNUSED, $urandom());
        queue_ticks(160);
        hold_requests <= hold_requests + 1;
        wait_drained();

        write_reg(jnp_pkg::REG_PATTERN, 32'h0000_0000);
        write_reg(jnp_pkg::REG_THRESHOLD, 32'd0);
        queue_ticks(128);
        wait_drained();

        write_reg(jnp_pkg::REG_PATTERN, 32'hFFFF_FFFF);
        write_reg(jnp_pkg::REG_THRESHOLD, 32'd32);
        queue_ticks(128);
        wait_drained();

        // threshold beyond the window: nobody reads plugged
        write_reg(jnp_pkg::REG_PATTERN, $urandom());
        write_reg(jnp_pkg::REG_THRESHOLD, {26'($urandom_range(0, 32'h03FF_FFFF)), 6'd63});
        queue_ticks(96);
        wait_drained();

        write_reg(jnp_pkg::REG_THRESHOLD, 32'd33);
        queue_ticks(64);
        wait_drained();

        // calibration freezes the window and holds the flags
        write_reg(jnp_pkg::REG_CALIBRATING, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
        queue_ticks(48);
        wait_drained();

        write_reg(jnp_pkg::REG_CALIBRATING, 32'd0);
        write_reg(jnp_pkg::REG_PATTERN, $urandom());
        write_reg(jnp_pkg::REG_THRESHOLD, 32'd31);
        queue_ticks(160);
        hold_requests <= hold_requests + 1;
        wait_drained();

        while (ticks_queued < TOTAL_TICKS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(jnp_pkg::REG_PATTERN,
                          ($urandom_range(0, 3) == 0) ? 32'hAAAA_AAAA : $urandom());
            end
            case ($urandom_range(0, 5))
                0:       write_reg(jnp_pkg::REG_THRESHOLD, 32'd0);
                1:       write_reg(jnp_pkg::REG_THRESHOLD, 32'd32);
                default: write_reg(jnp_pkg::REG_THRESHOLD, $urandom_range(0, 40));
            endcase
            write_reg(jnp_pkg::REG_CALIBRATING, 32'($urandom_range(0, 5) == 0));
            queue_ticks($urandom_range(40, 160));
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS jack_normalization_probe");
        end
        else
        begin
            $display("FAIL jack_normalization_probe");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/jnp_pkg.sv
design/jnp_lane.sv
design/jnp_merge.sv
design/jack_normalization_probe.sv
design/jnp_checker.sv
tb/tb_top.sv
